// File: src/mts_pkg.sv
// Shared types and codes for the minimum-tracking stack.
// Used by the channel interfaces, the result stage and the top level.
package mts_pkg;

	// Operation codes on the request channel. The unused code behaves as a read.
	typedef logic [1:0] func_t;
	localparam func_t FUNC_PUSH = 2'd0;
	localparam func_t FUNC_POP  = 2'd1;
	localparam func_t FUNC_READ = 2'd2;

	// Completion status returned with every result.
	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_OVERFLOW  = 2'd1;
	localparam status_t STATUS_UNDERFLOW = 2'd2;

endpackage

// File: src/mts_if.sv
// Valid/ready channel interfaces for the minimum-tracking stack.
// Depends on mts_pkg for the operation and status types.

interface mts_req_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	mts_pkg::func_t                func;
	logic signed [VALUE_WIDTH-1:0] push_value;

	modport source (output valid, output func, output push_value, input ready);
	modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface mts_rsp_if #(
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 7
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] top_value;
	logic signed [VALUE_WIDTH-1:0] min_value;
	logic [COUNT_WIDTH-1:0]        entry_count;
	mts_pkg::status_t              status;

	modport source (output valid, output top_value, output min_value,
		output entry_count, output status, input ready);
	modport sink   (input valid, input top_value, input min_value,
		input entry_count, input status, output ready);
endinterface

// File: src/mts_out_stage.sv
// Registered result stage that drives the response channel.
// Depends on mts_pkg and mts_rsp_if.
module mts_out_stage #(
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic signed [VALUE_WIDTH-1:0] top_value,
	input  logic signed [VALUE_WIDTH-1:0] min_value,
	input  logic [COUNT_WIDTH-1:0]        entry_count,
	input  mts_pkg::status_t              status,
	output logic                          can_load,
	mts_rsp_if.source                     rsp
);

	logic                          valid_q;
	logic signed [VALUE_WIDTH-1:0] top_q;
	logic signed [VALUE_WIDTH-1:0] min_q;
	logic [COUNT_WIDTH-1:0]        count_q;
	mts_pkg::status_t              status_q;

	// A new result may enter when the register is empty or is being drained.
	assign can_load = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			top_q    <= top_value;
			min_q    <= min_value;
			count_q  <= entry_count;
			status_q <= status;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.top_value   = top_q;
	assign rsp.min_value   = min_q;
	assign rsp.entry_count = count_q;
	assign rsp.status      = status_q;

endmodule

// File: src/min_tracking_stack.sv
// Minimum-tracking stack: push, pop and read with the current minimum reported.
// Push and read load a registered result as they are accepted; a pop that leaves
// entries behind first fetches the new top from the entry RAM and takes no request until done.
// Throughput is one item per cycle for push and read while the result stage is not stalled.
// Reset (asynchronous, active low) empties the stack and sets the minimum to the
// largest value; the entry RAM is not cleared, as only filled slots are ever read.
module min_tracking_stack #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	mts_req_if.sink  req,
	mts_rsp_if.source rsp
);

	localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
	localparam int ADDR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENTRY_WIDTH = VALUE_WIDTH + 1;

	// Two-state controller: IDLE takes requests, FETCH waits on a RAM read
	// that supplies the new top entry after a pop.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

	// Each RAM entry holds a marker bit above a value field. An unmarked entry
	// stores its own value. A marked entry was pushed as a new minimum: its
	// value is then the minimum register, and the field keeps the minimum that
	// was in force before, so that a pop can restore it.
	logic [ENTRY_WIDTH-1:0] mem [DEPTH];
	logic [ENTRY_WIDTH-1:0] rd_data_q;

	state_t                        state_q;
	logic [COUNT_WIDTH-1:0]        count_q;
	logic signed [VALUE_WIDTH-1:0] min_q;
	// Copy of the entry at the top of the stack, so push and read never wait
	// on the RAM. Only meaningful while the stack is not empty.
	logic [ENTRY_WIDTH-1:0]        top_entry_q;

	logic                          fire;
	logic                          can_load;
	logic                          is_empty;
	logic                          is_full;
	logic signed [VALUE_WIDTH-1:0] top_dec;
	logic signed [VALUE_WIDTH-1:0] fetch_dec;

	// Next-state and result signals from the combinational decode.
	state_t                        state_d;
	logic [COUNT_WIDTH-1:0]        count_d;
	logic signed [VALUE_WIDTH-1:0] min_d;
	logic [ENTRY_WIDTH-1:0]        top_entry_d;
	logic                          mem_we;
	logic [ADDR_WIDTH-1:0]         mem_waddr;
	logic [ENTRY_WIDTH-1:0]        mem_wdata;
	logic                          rd_en;
	logic [ADDR_WIDTH-1:0]         rd_addr;
	logic                          res_load;
	logic signed [VALUE_WIDTH-1:0] res_top;
	mts_pkg::status_t              res_status;

	assign fire     = req.valid && req.ready;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == COUNT_WIDTH'(DEPTH));

	// Decoded top for the cached entry and for the entry just read back.
	assign top_dec   = top_entry_q[VALUE_WIDTH] ? min_q : top_entry_q[VALUE_WIDTH-1:0];
	assign fetch_dec = rd_data_q[VALUE_WIDTH] ? min_q : rd_data_q[VALUE_WIDTH-1:0];

	// Requests are taken only from IDLE, and only when the result stage can
	// absorb a result in the same cycle.
	assign req.ready = (state_q == ST_IDLE) && can_load;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		min_d       = min_q;
		top_entry_d = top_entry_q;
		mem_we      = 1'b0;
		mem_waddr   = count_q[ADDR_WIDTH-1:0];
		mem_wdata   = {1'b0, req.push_value};
		rd_en       = 1'b0;
		rd_addr     = ADDR_WIDTH'(count_q - COUNT_WIDTH'(2));
		res_load    = 1'b0;
		res_top     = top_dec;
		res_status  = mts_pkg::STATUS_OK;

		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					res_load = 1'b1;
					case (req.func)
						mts_pkg::FUNC_PUSH: begin
							if (is_full) begin
								// Refused: everything stays as it was.
								res_status = mts_pkg::STATUS_OVERFLOW;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + COUNT_WIDTH'(1);
								res_top = req.push_value;
								if (!is_empty && (req.push_value < min_q)) begin
									// New minimum: remember the old one in the entry.
									mem_wdata = {1'b1, min_q};
								end
								if (is_empty || (req.push_value < min_q)) begin
									min_d = req.push_value;
								end
								top_entry_d = mem_wdata;
							end
						end
						mts_pkg::FUNC_POP: begin
							if (is_empty) begin
								res_status = mts_pkg::STATUS_UNDERFLOW;
								res_top    = '0;
							end else begin
								count_d = count_q - COUNT_WIDTH'(1);
								if (top_entry_q[VALUE_WIDTH]) begin
									min_d = top_entry_q[VALUE_WIDTH-1:0];
								end
								if (count_q == COUNT_WIDTH'(1)) begin
									// Stack becomes empty; the minimum keeps its value.
									res_top = '0;
								end else begin
									// The new top has to come from the RAM first.
									res_load = 1'b0;
									rd_en    = 1'b1;
									state_d  = ST_FETCH;
								end
							end
						end
						default: begin
							// Read, and the unused code that behaves as one.
							if (is_empty) begin
								res_status = mts_pkg::STATUS_UNDERFLOW;
								res_top    = '0;
							end
						end
					endcase
				end
			end
			ST_FETCH: begin
				// The minimum was already restored when the pop was taken.
				res_top = fetch_dec;
				if (can_load) begin
					res_load    = 1'b1;
					top_entry_d = rd_data_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			min_q   <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			min_q   <= min_d;
		end
	end

	always_ff @(posedge clk) begin
		top_entry_q <= top_entry_d;
	end

	// Entry RAM: one write port, one read port with registered data. A write
	// only happens on a push and a read only on a pop, so they never meet.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	mts_out_stage #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (res_load),
		.top_value   (res_top),
		.min_value   (min_d),
		.entry_count (count_d),
		.status      (res_status),
		.can_load    (can_load),
		.rsp         (rsp)
	);

	// The fill count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_WIDTH'(DEPTH))
		else $error("stack count exceeds depth");

	// The RAM is never written and read in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("entry RAM write and read collide");

	// A pop that leaves entries behind goes to the fetch state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req.func == mts_pkg::FUNC_POP) && (count_q > COUNT_WIDTH'(1)))
		|=> (state_q == ST_FETCH))
		else $error("pop did not fetch the new top");

	// An accepted push on a stack that is not full grows it by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req.func == mts_pkg::FUNC_PUSH) && !is_full)
		|=> (count_q == $past(count_q) + COUNT_WIDTH'(1)))
		else $error("push did not advance the count");

endmodule
